FILE: rtl/core/ppmp_pkg.sv
// Shared types and constants of the PPM stream parser.
// Used by ppmp_parse, ppmp_rsp_fifo and ppm_stream_parser_unit.
package ppmp_pkg;

   localparam int unsigned MAX_DIM_DEF = 8192;
   localparam int unsigned FRAME_W     = 14;
   localparam int unsigned LEFT_W      = 28;
   localparam logic [LEFT_W-1:0] LEFT_MAX = '1;

   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [1:0] KIND_HEADER    = 2'd0;
   localparam logic [1:0] KIND_COMPONENT = 2'd1;
   localparam logic [1:0] KIND_ERROR     = 2'd2;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_HEADER  = 3'd1;
   localparam logic [2:0] ERR_BAD_DIM     = 3'd2;
   localparam logic [2:0] ERR_SHORT_DATA  = 3'd3;
   localparam logic [2:0] ERR_RANGE       = 3'd4;
   localparam logic [2:0] ERR_NOT_NUMERIC = 3'd5;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_FIVE  = 8'h35;
   localparam logic [7:0] CH_SIX   = 8'h36;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_P     = 8'h50;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [7:0]         component_value;
      logic [FRAME_W-1:0] frame_width;
      logic [FRAME_W-1:0] frame_height;
      logic               is_p3_text;
      logic               final_component;
      logic [2:0]         error_code;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic         vld0;
      logic         vld1;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_pair_type;

endpackage

FILE: rtl/core/ppmp_parse.sv
// Input register, header/data parse state and per-byte next-state logic.
// Produces up to two results per byte toward the response FIFO. Uses ppmp_pkg.
module ppmp_parse #(
   parameter int unsigned MAX_DIM = ppmp_pkg::MAX_DIM_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ppmp_pkg::req_item_type req_item,
   input  logic                  fifo_room,
   output ppmp_pkg::rsp_pair_type push
);
   import ppmp_pkg::*;

   localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
   localparam int unsigned PROD_W = 2 * DIM_W + 2;
   localparam int unsigned CNT_W  = (PROD_W > LEFT_W) ? PROD_W : LEFT_W;
   localparam logic [31:0] MAX_DIM_V = 32'(MAX_DIM);

   localparam logic [1:0] HERR_NONE   = 2'd0;
   localparam logic [1:0] HERR_HEADER = 2'd1;
   localparam logic [1:0] HERR_DIM    = 2'd2;

   typedef enum logic [2:0] {
      PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_DATA, PH_DONE
   } phase_type;

   function automatic rsp_item_type err_item(input logic [2:0] code);
      rsp_item_type r;
      r = '0;
      r.result_kind = KIND_ERROR;
      r.error_code  = code;
      return r;
   endfunction

   function automatic rsp_item_type comp_item(input logic [7:0] value, input logic fin);
      rsp_item_type r;
      r = '0;
      r.result_kind     = KIND_COMPONENT;
      r.component_value = value;
      r.final_component = fin;
      return r;
   endfunction

   logic                in_vld_ff;
   req_item_type        item_ff;
   phase_type           phase_ff, phase_in;
   logic                text_ff, text_in;
   logic                comment_ff, comment_in;
   logic                in_token_ff, in_token_in;
   logic [1:0]          match_ff, match_in;
   logic [2:0]          tcnt_ff, tcnt_in;
   logic [31:0]         acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic                dig_ff, dig_in;
   logic                stop_ff, stop_in;
   logic                ovf_ff, ovf_in;
   logic [1:0]          herr_ff, herr_in;
   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic [LEFT_W-1:0]   total_ff;

   logic                go;
   logic [7:0]          ch;
   logic                ch_ws;
   logic [2*DIM_W-1:0]  wh;
   logic [CNT_W-1:0]    wh3;
   logic [LEFT_W-1:0]   left_dec;

   assign go        = in_vld_ff && fifo_room;
   assign req_stall = in_vld_ff && !fifo_room;
   assign ch        = item_ff.data_byte;
   assign ch_ws     = ((ch >= CH_TAB) && (ch <= CH_CR)) || (ch == CH_SPACE);
   assign wh        = width_ff * height_ff;
   assign wh3       = CNT_W'({wh, 1'b0}) + CNT_W'(wh);
   assign left_dec  = left_ff - LEFT_W'(left_ff != '0);

   // feed one token character
   logic [2:0]  fd_cnt;
   logic [1:0]  fd_match;
   logic [31:0] fd_acc;
   logic        fd_neg, fd_dig, fd_stop, fd_ovf;

   always_comb begin
      logic [2:0]  k;
      logic [35:0] v;
      logic [35:0] lim;
      k        = in_token_ff ? tcnt_ff : 3'd0;
      fd_match = in_token_ff ? match_ff : 2'b11;
      fd_acc   = in_token_ff ? acc_ff : 32'd0;
      fd_neg   = in_token_ff && neg_ff;
      fd_dig   = in_token_ff && dig_ff;
      fd_stop  = in_token_ff && stop_ff;
      fd_ovf   = in_token_ff && ovf_ff;
      if (phase_ff == PH_MAGIC) begin
         if (k == 3'd0 && ch != CH_P) fd_match = 2'b00;
         if (k == 3'd1) begin
            if (ch != CH_THREE) fd_match[0] = 1'b0;
            if (ch != CH_SIX) fd_match[1] = 1'b0;
         end
         if (k >= 3'd2) fd_match = 2'b00;
      end else if (phase_ff == PH_MAXV) begin
         if (k >= 3'd3 || ch != ((k == 3'd0) ? CH_TWO : CH_FIVE)) fd_match = 2'b00;
      end
      fd_cnt = (k == 3'd7) ? k : k + 3'd1;
      lim    = fd_neg ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
      v      = ({4'd0, fd_acc} << 3) + ({4'd0, fd_acc} << 1) + 36'(ch - CH_ZERO);
      if (!fd_stop) begin
         if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (v > lim) begin
               v      = lim;
               fd_ovf = 1'b1;
            end
            fd_acc = v[31:0];
            fd_dig = 1'b1;
         end else if (k == 3'd0 && (ch == CH_PLUS || ch == CH_MINUS)) begin
            if (ch == CH_MINUS) fd_neg = 1'b1;
         end else begin
            fd_stop = 1'b1;
         end
      end
   end

   // end of token
   phase_type         f_phase;
   logic              f_text;
   logic [1:0]        f_herr;
   logic [DIM_W-1:0]  f_width, f_height;
   logic [LEFT_W-1:0] f_left;
   logic              f_vld;
   rsp_item_type      f_res;

   always_comb begin
      logic       num_ok;
      logic       dim_ok;
      logic [1:0] herr_t;
      num_ok   = dig_ff && !ovf_ff;
      dim_ok   = num_ok && !neg_ff && acc_ff != 32'd0 && acc_ff <= MAX_DIM_V;
      herr_t   = herr_ff;
      f_phase  = phase_ff;
      f_text   = text_ff;
      f_herr   = herr_ff;
      f_width  = width_ff;
      f_height = height_ff;
      f_left   = left_ff;
      f_vld    = 1'b0;
      f_res    = '0;
      unique case (phase_ff)
         PH_MAGIC: begin
            if (tcnt_ff == 3'd2 && match_ff != 2'b00) f_text = match_ff[0];
            else f_herr = HERR_HEADER;
            f_phase = PH_WIDTH;
         end
         PH_WIDTH, PH_HEIGHT: begin
            if (dim_ok) begin
               if (phase_ff == PH_WIDTH) f_width = acc_ff[DIM_W-1:0];
               else f_height = acc_ff[DIM_W-1:0];
            end else if (herr_ff == HERR_NONE) begin
               f_herr = HERR_DIM;
            end
            f_phase = (phase_ff == PH_WIDTH) ? PH_HEIGHT : PH_MAXV;
         end
         PH_MAXV: begin
            if (!(tcnt_ff == 3'd3 && match_ff[0])) herr_t = HERR_HEADER;
            f_herr = herr_t;
            f_vld  = 1'b1;
            if (herr_t != HERR_NONE) begin
               f_res   = err_item((herr_t == HERR_HEADER) ? ERR_BAD_HEADER : ERR_BAD_DIM);
               f_phase = PH_DONE;
            end else begin
               f_left             = total_ff;
               f_res              = '0;
               f_res.result_kind  = KIND_HEADER;
               f_res.frame_width  = FRAME_W'(width_ff);
               f_res.frame_height = FRAME_W'(height_ff);
               f_res.is_p3_text   = text_ff;
               f_phase            = PH_DATA;
            end
         end
         PH_DATA: begin
            f_vld = 1'b1;
            if (!num_ok) begin
               f_res   = err_item(ERR_NOT_NUMERIC);
               f_phase = PH_DONE;
            end else if ((neg_ff && acc_ff != 32'd0) || acc_ff > 32'd255) begin
               f_res   = err_item(ERR_RANGE);
               f_phase = PH_DONE;
            end else begin
               f_left = left_dec;
               f_res  = comp_item(acc_ff[7:0], left_dec == '0);
               if (left_dec == '0) f_phase = PH_DONE;
            end
         end
         default: ;
      endcase
   end

   // per-byte next state
   logic         ra_vld, rb_vld;
   rsp_item_type ra, rb;

   always_comb begin
      logic      do_fin;
      phase_type s1_phase;
      phase_type ph;
      ph          = phase_ff;
      phase_in    = phase_ff;
      text_in     = text_ff;
      comment_in  = comment_ff;
      in_token_in = in_token_ff;
      match_in    = match_ff;
      tcnt_in     = tcnt_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      dig_in      = dig_ff;
      stop_in     = stop_ff;
      ovf_in      = ovf_ff;
      herr_in     = herr_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      left_in     = left_ff;
      ra_vld      = 1'b0;
      rb_vld      = 1'b0;
      ra          = '0;
      rb          = '0;
      do_fin      = in_token_ff && (ph < PH_DATA || (ph == PH_DATA && text_ff));
      s1_phase    = do_fin ? f_phase : phase_ff;
      if (item_ff.end_of_stream) begin
         ra_vld = do_fin && f_vld;
         ra     = f_res;
         if (s1_phase < PH_DATA) begin
            rb_vld = 1'b1;
            rb     = err_item(ERR_BAD_HEADER);
         end else if (s1_phase == PH_DATA) begin
            rb_vld = 1'b1;
            rb     = err_item(ERR_SHORT_DATA);
         end
         phase_in    = PH_MAGIC;
         text_in     = 1'b0;
         comment_in  = 1'b0;
         in_token_in = 1'b0;
         match_in    = '0;
         tcnt_in     = '0;
         acc_in      = '0;
         neg_in      = 1'b0;
         dig_in      = 1'b0;
         stop_in     = 1'b0;
         ovf_in      = 1'b0;
         herr_in     = HERR_NONE;
         width_in    = '0;
         height_in   = '0;
         left_in     = '0;
      end else if (ph >= PH_DONE) begin
         phase_in = phase_ff;
      end else if (ph == PH_DATA && !text_ff) begin
         left_in = left_dec;
         ra_vld  = 1'b1;
         ra      = comp_item(ch, left_dec == '0);
         if (left_dec == '0) phase_in = PH_DONE;
      end else if (comment_ff) begin
         if (ch == CH_LF) comment_in = 1'b0;
      end else if (in_token_ff && ch_ws) begin
         in_token_in = 1'b0;
         phase_in    = f_phase;
         text_in     = f_text;
         herr_in     = f_herr;
         width_in    = f_width;
         height_in   = f_height;
         left_in     = f_left;
         ra_vld      = f_vld;
         ra          = f_res;
      end else if (!in_token_ff && ch == CH_HASH) begin
         comment_in = 1'b1;
      end else if (in_token_ff || !ch_ws) begin
         in_token_in = 1'b1;
         match_in    = fd_match;
         tcnt_in     = fd_cnt;
         acc_in      = fd_acc;
         neg_in      = fd_neg;
         dig_in      = fd_dig;
         stop_in     = fd_stop;
         ovf_in      = fd_ovf;
      end
   end

   always_comb begin
      push       = '0;
      push.vld0  = go && (ra_vld || rb_vld);
      push.vld1  = go && ra_vld && rb_vld;
      push.item0 = ra_vld ? ra : rb;
      push.item1 = rb;
      push.item0.last = !(ra_vld && rb_vld);
      push.item1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) item_ff <= req_item;
      total_ff <= (wh3 > CNT_W'(LEFT_MAX)) ? LEFT_MAX : wh3[LEFT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         phase_ff    <= PH_MAGIC;
         text_ff     <= 1'b0;
         comment_ff  <= 1'b0;
         in_token_ff <= 1'b0;
         match_ff    <= '0;
         tcnt_ff     <= '0;
         acc_ff      <= '0;
         neg_ff      <= 1'b0;
         dig_ff      <= 1'b0;
         stop_ff     <= 1'b0;
         ovf_ff      <= 1'b0;
         herr_ff     <= HERR_NONE;
         width_ff    <= '0;
         height_ff   <= '0;
         left_ff     <= '0;
      end else begin
         if (req_valid && !req_stall) in_vld_ff <= 1'b1;
         else if (go) in_vld_ff <= 1'b0;
         if (go) begin
            phase_ff    <= phase_in;
            text_ff     <= text_in;
            comment_ff  <= comment_in;
            in_token_ff <= in_token_in;
            match_ff    <= match_in;
            tcnt_ff     <= tcnt_in;
            acc_ff      <= acc_in;
            neg_ff      <= neg_in;
            dig_ff      <= dig_in;
            stop_ff     <= stop_in;
            ovf_ff      <= ovf_in;
            herr_ff     <= herr_in;
            width_ff    <= width_in;
            height_ff   <= height_in;
            left_ff     <= left_in;
         end
      end
   end

   a_eos_rearms: assert property (@(posedge clock) disable iff (reset)
      go && item_ff.end_of_stream |=> phase_ff == PH_MAGIC && !in_token_ff && !comment_ff)
      else $error("parser not rearmed after end of stream");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      push.vld0 && !push.vld1 |-> push.item0.last)
      else $error("single result without last");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      push.vld1 |-> push.vld0 && push.item1.last && !push.item0.last)
      else $error("result pair badly ordered");

endmodule

FILE: rtl/core/ppmp_rsp_fifo.sv
// Response FIFO: takes up to two results per cycle, hands out one per transfer.
// Uses ppmp_pkg.
module ppmp_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  ppmp_pkg::rsp_pair_type push,
   output logic                   fifo_room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ppmp_pkg::rsp_item_type rsp_item
);
   import ppmp_pkg::*;

   localparam logic [RSP_CNT_W-1:0] ROOM_LIMIT = RSP_CNT_W'(RSP_DEPTH - 2);
   localparam logic [RSP_CNT_W-1:0] FULL_CNT   = RSP_CNT_W'(RSP_DEPTH);

   rsp_item_type           mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign fifo_room = count_ff <= ROOM_LIMIT;
   assign rsp_valid = count_ff != '0;
   assign rsp_item  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.vld0) + RSP_PTR_W'(push.vld1);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(push.vld0) + RSP_CNT_W'(push.vld1)
                      - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.vld0) mem_ff[wr_ptr_ff] <= push.item0;
      if (push.vld1) mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push.item1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("response fifo overflow");

   a_push_with_room: assert property (@(posedge clock) disable iff (reset)
      push.vld0 |-> count_ff <= ROOM_LIMIT)
      else $error("push without room for two results");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

endmodule

FILE: rtl/core/ppm_stream_parser_unit.sv
// PPM (P3/P6, maxval 255) stream parser, top level.
// Depends on ppmp_pkg, ppmp_parse and ppmp_rsp_fifo.
//
// Usage:
//   req channel: one file byte per transfer (data_byte), or an end_of_stream
//   marker that closes the file, flushes a pending token and rearms the parser.
//   rsp channel: header, component and error results, one per transfer; last
//   marks the final result caused by one request.
// Path: a taken request is held in the input register; it is parsed from there
//   when the FIFO has room, and its results are written into the rsp FIFO.
// Throughput: one byte per cycle while rsp drains. A request that yields two
//   results (end_of_stream only) takes two rsp transfers.
// Stall: req_stall rises when a byte is held and the 4-entry response FIFO
//   has under two free slots; a stalled rsp holds its result until transferred.
// Reset: parser returns to waiting for the magic token, FIFO empties, no
//   result is pending.
module ppm_stream_parser_unit #(
   parameter int unsigned MAX_DIM = ppmp_pkg::MAX_DIM_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ppmp_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ppmp_pkg::rsp_item_type rsp_item
);
   import ppmp_pkg::*;

   rsp_pair_type push;
   logic         fifo_room;

   ppmp_parse #(
      .MAX_DIM (MAX_DIM)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .fifo_room (fifo_room),
      .push      (push)
   );

   ppmp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .fifo_room (fifo_room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
